FILE: rtl/pats_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pats_pkg
// Types, constants and helper functions shared by the task scheduler files.
// ----------------------------------------------------------------------------
package pats_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int SLOT_W     = $clog2(TASK_SLOTS);
   localparam int COUNT_W    = $clog2(TASK_SLOTS + 1);
   localparam int PRIO_W     = 6;
   localparam int STEP_W     = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [PRIO_W-1:0] PRIO_BEST_RESET  = -6'sd20;
   localparam logic signed [PRIO_W-1:0] PRIO_WORST_RESET = 6'sd20;
   localparam logic [STEP_W-1:0]        AGING_STEP_RESET = 5'd1;
   localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

   localparam logic [1:0] REG_PRIO_BEST  = 2'd0;
   localparam logic [1:0] REG_PRIO_WORST = 2'd1;
   localparam logic [1:0] REG_AGING_STEP = 2'd2;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_SET    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_SCHED  = 2'd3
   } func_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SLOT  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ADD_TAIL,
      S_WALK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio_best;
      logic signed [PRIO_W-1:0] prio_worst;
      logic [STEP_W-1:0]        aging_step;
   } cfg_type;

   function automatic logic signed [PRIO_W-1:0] clamp_prio(
      input logic signed [PRIO_W-1:0] req,
      input logic signed [PRIO_W-1:0] best,
      input logic signed [PRIO_W-1:0] worst);
      logic signed [PRIO_W-1:0] v;
      v = req;
      if (v > worst) begin
         v = worst;
      end
      if (v < best) begin
         v = best;
      end
      return v;
   endfunction

   function automatic logic signed [PRIO_W-1:0] age_prio(
      input logic signed [PRIO_W-1:0] v,
      input logic [STEP_W-1:0]        step);
      logic signed [PRIO_W:0] diff;
      diff = $signed({v[PRIO_W-1], v}) - $signed({{(PRIO_W+1-STEP_W){1'b0}}, step});
      if (diff[PRIO_W] != diff[PRIO_W-1]) begin
         return PRIO_MIN;
      end
      return diff[PRIO_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/pats_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pats_csr
// Configuration registers of the task scheduler behind an APB-style port.
// ----------------------------------------------------------------------------
module pats_csr
   import pats_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       write_en;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_PRIO_BEST:  cfg_in.prio_best  = csr_pwdata[PRIO_W-1:0];
            REG_PRIO_WORST: cfg_in.prio_worst = csr_pwdata[PRIO_W-1:0];
            REG_AGING_STEP: cfg_in.aging_step = csr_pwdata[STEP_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PRIO_BEST:  csr_prdata = {{(CSR_DATA_W-PRIO_W){1'b0}}, cfg_ff.prio_best};
         REG_PRIO_WORST: csr_prdata = {{(CSR_DATA_W-PRIO_W){1'b0}}, cfg_ff.prio_worst};
         REG_AGING_STEP: csr_prdata = {{(CSR_DATA_W-STEP_W){1'b0}}, cfg_ff.aging_step};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prio_best  <= PRIO_BEST_RESET;
         cfg_ff.prio_worst <= PRIO_WORST_RESET;
         cfg_ff.aging_step <= AGING_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/priority_aging_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_aging_task_scheduler
// Ring of ready tasks with static and dynamic priorities and aging.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries one command: add a task slot,
// set its priority, remove it, or schedule. Each command gives exactly one
// transfer on the rsp_ channel with the chosen slot, a valid flag and a
// status code. Configuration is to be written by the user through the csr_
// port only while the block is idle; the block itself does not enforce this.
// The block works on one command at a time and drops req_ready while busy.
// Set priority, remove and rejected commands pass through S_EXEC and then
// S_RESP; an accepted add on a non-empty ring passes S_ADD_TAIL between
// the two, and schedule on a ring of two or more tasks passes S_WALK,
// where the sequencer visits one ring entry per cycle through the shared
// compare and aging unit. req_ready rises in the cycle after the result
// is loaded. The result sits in an output register; while the receiver
// stalls a further result waits until the held one is taken.
// Reset empties the ring, clears all priorities and loads the register
// defaults. No memory sweep follows reset.
// ----------------------------------------------------------------------------
module priority_aging_task_scheduler
   import pats_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_func,
   input  wire logic [SLOT_W-1:0]        req_task_slot,
   input  wire logic signed [PRIO_W-1:0] req_prio,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [SLOT_W-1:0]             rsp_chosen_task,
   output logic                          rsp_chosen_valid,
   output logic [1:0]                    rsp_status,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [CSR_DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   cfg_type cfg;

   pats_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Task table.
   logic [TASK_SLOTS-1:0]    in_ring_ff;
   logic signed [PRIO_W-1:0] static_prio_ff  [TASK_SLOTS];
   logic signed [PRIO_W-1:0] dynamic_prio_ff [TASK_SLOTS];
   logic [SLOT_W-1:0]        next_link_ff    [TASK_SLOTS];
   logic [SLOT_W-1:0]        prev_link_ff    [TASK_SLOTS];

   // Sequencer state.
   state_type                state_ff, state_in;
   func_type                 func_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic signed [PRIO_W-1:0] prio_ff;
   logic [SLOT_W-1:0]        head_ff, head_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [SLOT_W-1:0]        cur_ff, cur_in;
   logic [SLOT_W-1:0]        best_ff, best_in;
   logic signed [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [COUNT_W-1:0]       iter_ff, iter_in;
   logic [SLOT_W-1:0]        tail_ff, tail_in;
   logic [SLOT_W-1:0]        res_chosen_ff, res_chosen_in;
   logic                     res_valid_ff, res_valid_in;
   logic [1:0]               res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]        rsp_chosen_ff;
   logic                     rsp_chosen_valid_ff;
   logic [1:0]               rsp_status_ff;

   // Table write controls.
   logic                     ring_we, ring_wdata;
   logic                     prio_we;
   logic signed [PRIO_W-1:0] prio_wdata;
   logic                     dyn_we;
   logic [SLOT_W-1:0]        dyn_waddr;
   logic signed [PRIO_W-1:0] dyn_wdata;
   logic                     next_we, prev_we;
   logic [SLOT_W-1:0]        next_waddr, next_wdata, prev_waddr, prev_wdata;

   // Table reads.
   logic [SLOT_W-1:0]        link_raddr;
   logic [SLOT_W-1:0]        next_rd, prev_rd;
   logic signed [PRIO_W-1:0] dyn_rd, static_rd;
   logic                     ring_rd;

   logic                     req_fire, rsp_load;
   logic                     slot_ok, walk_last, walk_better, walk_age;

   assign req_fire = req_valid & req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load = (state_ff == S_RESP) & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      if (state_ff == S_WALK) begin
         link_raddr = cur_ff;
      end else if (func_ff == FUNC_ADD || func_ff == FUNC_SCHED) begin
         link_raddr = head_ff;
      end else begin
         link_raddr = slot_ff;
      end
   end

   assign next_rd   = next_link_ff[link_raddr];
   assign prev_rd   = prev_link_ff[link_raddr];
   assign dyn_rd    = dynamic_prio_ff[cur_ff];
   assign static_rd = static_prio_ff[head_ff];
   assign ring_rd   = in_ring_ff[slot_ff];

   assign slot_ok     = ({1'b0, slot_ff} < (SLOT_W+1)'(TASK_SLOTS));
   assign walk_last   = ((iter_ff + COUNT_W'(1)) == count_ff);
   assign walk_better = (dyn_rd < best_prio_ff);
   assign walk_age    = ~walk_better & (cur_ff != best_ff) & (dyn_rd > cfg.prio_best);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (func_ff == FUNC_ADD && slot_ok && !ring_rd && count_ff != '0) begin
               state_in = S_ADD_TAIL;
            end else if (func_ff == FUNC_SCHED && count_ff > COUNT_W'(1)) begin
               state_in = S_WALK;
            end
         end
         S_ADD_TAIL: state_in = S_RESP;
         S_WALK: begin
            if (walk_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      best_prio_in  = best_prio_ff;
      iter_in       = iter_ff;
      tail_in       = tail_ff;
      res_chosen_in = res_chosen_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      ring_we       = 1'b0;
      ring_wdata    = 1'b0;
      prio_we       = 1'b0;
      prio_wdata    = '0;
      dyn_we        = 1'b0;
      dyn_waddr     = slot_ff;
      dyn_wdata     = '0;
      next_we       = 1'b0;
      next_waddr    = slot_ff;
      next_wdata    = head_ff;
      prev_we       = 1'b0;
      prev_waddr    = slot_ff;
      prev_wdata    = tail_ff;
      unique case (state_ff)
         S_EXEC: begin
            res_chosen_in = '0;
            res_valid_in  = 1'b0;
            res_status_in = STATUS_OK;
            unique case (func_ff)
               FUNC_ADD: begin
                  if (!slot_ok || ring_rd) begin
                     res_status_in = STATUS_SLOT;
                  end else begin
                     prio_we    = 1'b1;
                     prio_wdata = '0;
                     ring_we    = 1'b1;
                     ring_wdata = 1'b1;
                     count_in   = count_ff + COUNT_W'(1);
                     next_we    = 1'b1;
                     prev_we    = 1'b1;
                     if (count_ff == '0) begin
                        head_in    = slot_ff;
                        next_wdata = slot_ff;
                        prev_wdata = slot_ff;
                     end else begin
                        tail_in    = prev_rd;
                        next_wdata = head_ff;
                        prev_waddr = head_ff;
                        prev_wdata = slot_ff;
                     end
                  end
               end
               FUNC_SET: begin
                  if (!slot_ok) begin
                     res_status_in = STATUS_SLOT;
                  end else begin
                     prio_we    = 1'b1;
                     prio_wdata = clamp_prio(prio_ff, cfg.prio_best, cfg.prio_worst);
                  end
               end
               FUNC_REMOVE: begin
                  if (!slot_ok || !ring_rd) begin
                     res_status_in = STATUS_SLOT;
                  end else begin
                     ring_we    = 1'b1;
                     ring_wdata = 1'b0;
                     count_in   = count_ff - COUNT_W'(1);
                     if (count_ff == COUNT_W'(1)) begin
                        head_in = '0;
                     end else begin
                        next_we    = 1'b1;
                        next_waddr = prev_rd;
                        next_wdata = next_rd;
                        prev_we    = 1'b1;
                        prev_waddr = next_rd;
                        prev_wdata = prev_rd;
                        if (head_ff == slot_ff) begin
                           head_in = next_rd;
                        end
                     end
                  end
               end
               FUNC_SCHED: begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     dyn_we        = 1'b1;
                     dyn_waddr     = head_ff;
                     dyn_wdata     = static_rd;
                     best_in       = head_ff;
                     best_prio_in  = static_rd;
                     cur_in        = next_rd;
                     iter_in       = COUNT_W'(1);
                     res_chosen_in = head_ff;
                     res_valid_in  = 1'b1;
                  end
               end
               default: res_status_in = STATUS_OK;
            endcase
         end
         S_ADD_TAIL: begin
            next_we    = 1'b1;
            next_waddr = tail_ff;
            next_wdata = slot_ff;
            prev_we    = 1'b1;
            prev_waddr = slot_ff;
            prev_wdata = tail_ff;
         end
         S_WALK: begin
            if (walk_better) begin
               best_in      = cur_ff;
               best_prio_in = dyn_rd;
            end else if (walk_age) begin
               dyn_we    = 1'b1;
               dyn_waddr = cur_ff;
               dyn_wdata = age_prio(dyn_rd, cfg.aging_step);
            end
            cur_in  = next_rd;
            iter_in = iter_ff + COUNT_W'(1);
            if (walk_last) begin
               head_in       = best_in;
               res_chosen_in = best_in;
            end
         end
         default: begin
            head_in = head_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         in_ring_ff   <= '0;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            static_prio_ff[i]  <= '0;
            dynamic_prio_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ring_we) begin
            in_ring_ff[slot_ff] <= ring_wdata;
         end
         if (prio_we) begin
            static_prio_ff[slot_ff]  <= prio_wdata;
            dynamic_prio_ff[slot_ff] <= prio_wdata;
         end else if (dyn_we) begin
            dynamic_prio_ff[dyn_waddr] <= dyn_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_link_ff[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_link_ff[prev_waddr] <= prev_wdata;
      end
      if (req_fire) begin
         func_ff <= func_type'(req_func);
         slot_ff <= req_task_slot;
         prio_ff <= req_prio;
      end
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      best_prio_ff  <= best_prio_in;
      iter_ff       <= iter_in;
      tail_ff       <= tail_in;
      res_chosen_ff <= res_chosen_in;
      res_valid_ff  <= res_valid_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_chosen_ff       <= res_chosen_ff;
         rsp_chosen_valid_ff <= res_valid_ff;
         rsp_status_ff       <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_task  = rsp_chosen_ff;
   assign rsp_chosen_valid = rsp_chosen_valid_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
`default_nettype wire

FILE: rtl/pats_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pats_checker
// Port-level checks of the task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pats_checker
   import pats_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [SLOT_W-1:0] rsp_chosen_task,
   input wire logic              rsp_chosen_valid,
   input wire logic [1:0]        rsp_status
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chosen_task)
         && $stable(rsp_chosen_valid) && $stable(rsp_status))
      else $error("Stalled result transfer changed.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Command accepted while the previous one is still running.");

   a_result_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chosen_valid ? rsp_status == STATUS_OK
                                      : rsp_chosen_task == '0)
         && (rsp_status == STATUS_OK || rsp_status == STATUS_SLOT
             || rsp_status == STATUS_EMPTY))
      else $error("Result fields disagree with each other.");

endmodule

bind priority_aging_task_scheduler pats_checker u_pats_checker (.*);
`default_nettype wire

FILE: tb/sv/priority_aging_task_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_aging_task_scheduler_test
// Self-checking bench for the aging priority task scheduler. A directed
// table of commands runs first, then random command streams run under a
// series of register settings. Each result is checked against an in-bench
// ring model or a fixed table row; channels idle at random but in one phase.
// ----------------------------------------------------------------------------
module priority_aging_task_scheduler_test;
   import pats_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 250;
   localparam int SETTING_COUNT  = 7;

   typedef struct packed {
      logic [SLOT_W-1:0] task_id;
      logic              chosen;
      logic [1:0]        status;
   } outcome_type;

   typedef struct packed {
      func_type                 func;
      logic [SLOT_W-1:0]        slot;
      logic signed [PRIO_W-1:0] prio;
      logic                     fixed;
      logic [SLOT_W-1:0]        exp_task;
      logic                     exp_chosen;
      logic [1:0]               exp_status;
   } cmd_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_func = '0;
   logic [SLOT_W-1:0]        req_task_slot = '0;
   logic signed [PRIO_W-1:0] req_prio = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [SLOT_W-1:0]        rsp_chosen_task;
   logic                     rsp_chosen_valid;
   logic [1:0]               rsp_status;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [CSR_DATA_W-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   logic                     req_fixed = 1'b0;
   outcome_type              req_fixed_outcome = '0;

   logic                     ring_member [TASK_SLOTS];
   logic signed [PRIO_W-1:0] base_prio [TASK_SLOTS];
   logic signed [PRIO_W-1:0] live_prio [TASK_SLOTS];
   logic [SLOT_W-1:0]        succ_slot [TASK_SLOTS];
   logic [SLOT_W-1:0]        pred_slot [TASK_SLOTS];
   logic [SLOT_W-1:0]        ring_head;
   int                       ring_size;
   logic signed [PRIO_W-1:0] cfg_best;
   logic signed [PRIO_W-1:0] cfg_worst;
   logic [STEP_W-1:0]        cfg_step;

   outcome_type pending_outcomes [$];
   int          err_count = 0;
   int          accepted_count = 0;
   int          checked_count = 0;
   int          chosen_count = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          steady = 1'b0;

   priority_aging_task_scheduler uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_task_slot    (req_task_slot),
      .req_prio         (req_prio),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chosen_task  (rsp_chosen_task),
      .rsp_chosen_valid (rsp_chosen_valid),
      .rsp_status       (rsp_status),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      err_count++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic outcome_type apply_command(input func_type f,
                                                 input logic [SLOT_W-1:0] s,
                                                 input logic signed [PRIO_W-1:0] p);
      outcome_type              o;
      logic signed [PRIO_W-1:0] r;
      logic [SLOT_W-1:0]        cur;
      logic [SLOT_W-1:0]        best;
      logic [SLOT_W-1:0]        nx;
      logic [SLOT_W-1:0]        pv;
      int                       v;
      o = '0;
      case (f)
         FUNC_ADD: begin
            if (ring_member[s]) begin
               o.status = STATUS_SLOT;
            end else begin
               base_prio[s] = '0;
               live_prio[s] = '0;
               if (ring_size == 0) begin
                  ring_head = s;
                  succ_slot[s] = s;
                  pred_slot[s] = s;
               end else begin
                  pv = pred_slot[ring_head];
                  succ_slot[pv] = s;
                  pred_slot[s] = pv;
                  succ_slot[s] = ring_head;
                  pred_slot[ring_head] = s;
               end
               ring_member[s] = 1'b1;
               ring_size++;
            end
         end
         FUNC_SET: begin
            r = p;
            if (r > cfg_worst) begin
               r = cfg_worst;
            end
            if (r < cfg_best) begin
               r = cfg_best;
            end
            base_prio[s] = r;
            live_prio[s] = r;
         end
         FUNC_REMOVE: begin
            if (!ring_member[s]) begin
               o.status = STATUS_SLOT;
            end else begin
               ring_member[s] = 1'b0;
               ring_size--;
               if (ring_size == 0) begin
                  ring_head = '0;
               end else begin
                  nx = succ_slot[s];
                  pv = pred_slot[s];
                  succ_slot[pv] = nx;
                  pred_slot[nx] = pv;
                  if (ring_head == s) begin
                     ring_head = nx;
                  end
               end
            end
         end
         default: begin
            if (ring_size == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               live_prio[ring_head] = base_prio[ring_head];
               best = ring_head;
               cur = ring_head;
               for (int i = 0; i < ring_size; i++) begin
                  if (live_prio[cur] < live_prio[best]) begin
                     best = cur;
                  end else if (cur != best && live_prio[cur] > cfg_best) begin
                     v = int'(live_prio[cur]) - int'(cfg_step);
                     live_prio[cur] = PRIO_W'((v < -32) ? -32 : v);
                  end
                  cur = succ_slot[cur];
               end
               ring_head = best;
               o.task_id = best;
               o.chosen = 1'b1;
            end
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               flag_error("result transfer with no command pending");
            end else begin
               want = pending_outcomes.pop_front();
               checked_count++;
               if (rsp_chosen_valid === 1'b1) begin
                  chosen_count++;
               end
               if (rsp_chosen_task !== want.task_id) begin
                  flag_error($sformatf("chosen_task: expected %0d, got %0d",
                                       want.task_id, rsp_chosen_task));
               end
               if (rsp_chosen_valid !== want.chosen) begin
                  flag_error($sformatf("chosen_valid: expected %0d, got %0d",
                                       want.chosen, rsp_chosen_valid));
               end
               if (rsp_status !== want.status) begin
                  flag_error($sformatf("status: expected %0d, got %0d",
                                       want.status, rsp_status));
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_command(func_type'(req_func), req_task_slot, req_prio);
            if (req_fixed) begin
               want = req_fixed_outcome;
            end
            pending_outcomes.push_back(want);
            accepted_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = gap_len();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Watchdog expired after %0d cycles without a transfer.", WATCHDOG_LIMIT);
      $display("priority_aging_task_scheduler_test: done, errors");
      $finish;
   end

   task automatic send_cmd(input cmd_row_type row);
      int gap;
      req_valid <= 1'b1;
      req_func <= row.func;
      req_task_slot <= row.slot;
      req_prio <= row.prio;
      req_fixed <= row.fixed;
      req_fixed_outcome <= '{row.exp_task, row.exp_chosen, row.exp_status};
      do @(posedge clock); while (!req_ready);
      gap = steady ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic [1:0] idx, input logic write,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (write) begin
         case (idx)
            REG_PRIO_BEST:  cfg_best = wdata[PRIO_W-1:0];
            REG_PRIO_WORST: cfg_worst = wdata[PRIO_W-1:0];
            REG_AGING_STEP: cfg_step = wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   endtask

   task automatic write_settings(input cfg_type c);
      logic [1:0]            regs [3];
      logic [CSR_DATA_W-1:0] words [3];
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] rd;
      regs = '{REG_PRIO_BEST, REG_PRIO_WORST, REG_AGING_STEP};
      words[0] = {{(CSR_DATA_W-PRIO_W){c.prio_best[PRIO_W-1]}}, c.prio_best};
      words[1] = {{(CSR_DATA_W-PRIO_W){c.prio_worst[PRIO_W-1]}}, c.prio_worst};
      words[2] = {{(CSR_DATA_W-STEP_W){1'b0}}, c.aging_step};
      for (int i = 0; i < 3; i++) begin
         csr_access(regs[i], 1'b1, words[i], rd);
      end
      for (int i = 0; i < 3; i++) begin
         csr_access(regs[i], 1'b0, '0, rd);
         mask = (regs[i] == REG_AGING_STEP) ? (32'd1 << STEP_W) - 1 : (32'd1 << PRIO_W) - 1;
         if ((rd & mask) !== (words[i] & mask)) begin
            flag_error($sformatf("register %0d reads back 0x%0h, wrote 0x%0h",
                                 regs[i], rd, words[i]));
         end
      end
   endtask

   task automatic run_random(input int count);
      cmd_row_type row;
      int          pick;
      int          cands [$];
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            drain_results();
         end
         row = '0;
         pick = $urandom_range(0, 99);
         if (ring_size <= 2 && pick >= 55 && pick < 75) begin
            pick = 0;
         end
         if (ring_size >= 14 && pick < 30) begin
            pick = 60;
         end
         if (pick < 30) begin
            row.func = FUNC_ADD;
         end else if (pick < 55) begin
            row.func = FUNC_SET;
         end else if (pick < 75) begin
            row.func = FUNC_REMOVE;
         end else begin
            row.func = FUNC_SCHED;
         end
         cands.delete();
         for (int s = 0; s < TASK_SLOTS; s++) begin
            if (ring_member[s] == (row.func != FUNC_ADD)) begin
               cands.push_back(s);
            end
         end
         if (cands.size() > 0 && row.func != FUNC_SCHED && $urandom_range(0, 9) < 8) begin
            row.slot = SLOT_W'(cands[$urandom_range(0, cands.size() - 1)]);
         end else begin
            row.slot = SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
         end
         if ($urandom_range(0, 7) == 0) begin
            row.prio = PRIO_W'($urandom_range(0, 1) ? -32 : 31);
         end else begin
            row.prio = PRIO_W'($urandom_range(0, 63));
         end
         send_cmd(row);
      end
   endtask

   initial begin : main
      cmd_row_type directed_rows [25];
      cfg_type     settings [SETTING_COUNT];
      for (int i = 0; i < TASK_SLOTS; i++) begin
         ring_member[i] = 1'b0;
         base_prio[i] = '0;
         live_prio[i] = '0;
         succ_slot[i] = '0;
         pred_slot[i] = '0;
      end
      ring_head = '0;
      ring_size = 0;
      cfg_best = PRIO_BEST_RESET;
      cfg_worst = PRIO_WORST_RESET;
      cfg_step = AGING_STEP_RESET;

      directed_rows = '{
         '{FUNC_SCHED,  0,   0, 1, 0, 0, STATUS_EMPTY},
         '{FUNC_REMOVE, 5,   0, 1, 0, 0, STATUS_SLOT},
         '{FUNC_SET,    3,  31, 1, 0, 0, STATUS_OK},
         '{FUNC_ADD,    0,   0, 1, 0, 0, STATUS_OK},
         '{FUNC_ADD,    0,   0, 1, 0, 0, STATUS_SLOT},
         '{FUNC_ADD,   15, -32, 1, 0, 0, STATUS_OK},
         '{FUNC_ADD,    3,   0, 1, 0, 0, STATUS_OK},
         '{FUNC_SET,   15,  31, 0, 0, 0, STATUS_OK},
         '{FUNC_SET,    0, -32, 0, 0, 0, STATUS_OK},
         '{FUNC_SET,    3,   5, 0, 0, 0, STATUS_OK},
         '{FUNC_SCHED,  0,   0, 0, 0, 0, STATUS_OK},
         '{FUNC_SCHED,  0,   0, 0, 0, 0, STATUS_OK},
         '{FUNC_SCHED,  0,   0, 0, 0, 0, STATUS_OK},
         '{FUNC_ADD,    9,   0, 0, 0, 0, STATUS_OK},
         '{FUNC_SET,    9,  -1, 0, 0, 0, STATUS_OK},
         '{FUNC_SCHED,  0,   0, 0, 0, 0, STATUS_OK},
         '{FUNC_REMOVE, 15,  0, 0, 0, 0, STATUS_OK},
         '{FUNC_SCHED,  0,   0, 0, 0, 0, STATUS_OK},
         '{FUNC_REMOVE, 0,   0, 0, 0, 0, STATUS_OK},
         '{FUNC_REMOVE, 3,   0, 0, 0, 0, STATUS_OK},
         '{FUNC_REMOVE, 9,   0, 0, 0, 0, STATUS_OK},
         '{FUNC_SCHED,  0,   0, 1, 0, 0, STATUS_EMPTY},
         '{FUNC_REMOVE, 9,   0, 1, 0, 0, STATUS_SLOT},
         '{FUNC_ADD,    7,   0, 1, 0, 0, STATUS_OK},
         '{FUNC_SCHED,  0,   0, 1, 7, 1, STATUS_OK}
      };

      settings = '{
         '{-32,  31,  0},
         '{-32,  31, 31},
         '{ 31, -32, 31},
         '{ 10, -10,  5},
         '{-32, -32,  1},
         '{  0,   0,  0},
         '{  0,   0,  0}
      };
      for (int k = 5; k < SETTING_COUNT; k++) begin
         settings[k].prio_best = PRIO_W'($urandom_range(0, 63));
         settings[k].prio_worst = PRIO_W'($urandom_range(0, 63));
         settings[k].aging_step = STEP_W'($urandom_range(0, 31));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_cmd(directed_rows[i]);
      end
      run_random(PHASE_ITEMS);

      for (int k = 0; k < SETTING_COUNT; k++) begin
         drain_results();
         write_settings(settings[k]);
         steady = (k == 1);
         run_random(PHASE_ITEMS);
         steady = 1'b0;
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));
      end

      $display("Ran %0d commands, checked %0d results, %0d of them picked a task.",
               accepted_count, checked_count, chosen_count);
      $display("Register settings covered: reset defaults plus %0d programmed sets.",
               SETTING_COUNT);
      if (err_count == 0) begin
         $display("priority_aging_task_scheduler_test: done, clean");
      end else begin
         $display("priority_aging_task_scheduler_test: done, errors");
      end
      $finish;
   end

endmodule
